>>> hw/rtl/tha_pkg.sv
// shared types, widths, codes and the arctangent table of the heading unit
// no dependencies; imported by every module of the block
package tha_pkg;

  // field widths
  localparam int TGT_W     = 16;
  localparam int CORNER_W  = 20;
  localparam int BOX_W     = 16;
  localparam int HEADING_W = 17;
  localparam int SPRITE_W  = 18;

  // fixed point formats
  localparam int POS_FRAC_BITS    = 4;
  localparam int ANGLE_FRAC_BITS  = 8;
  localparam int ACC_FRAC         = 16;
  localparam int TABLE_LEN        = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // datapath widths
  localparam int VEC_W       = 23;  // box-centre to target vector, signed
  localparam int MAG_W       = 22;  // magnitude of one component
  localparam int NORM_W      = 31;  // normalized operand, msb at bit 30
  localparam int NORM_STAGES = 5;   // shifts of 16, 8, 4, 2, 1
  localparam int XY_W        = 34;  // cordic x and y, signed, with gain headroom
  localparam int Z_W         = 25;  // angle accumulator, signed, 1/65536 degree
  localparam int ATAN_W      = 22;
  localparam int CLAMP_W     = 23;
  localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int PART_W      = 15;

  localparam logic [CLAMP_W-1:0]   Z_MAX         = CLAMP_W'(90 << ACC_FRAC);
  localparam logic [PART_W-1:0]    PART_RIGHT    = PART_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [SPRITE_W-1:0]  SPRITE_OFFSET = SPRITE_W'(180 << ANGLE_FRAC_BITS);

  // how the arctangent part is formed
  localparam logic [1:0] MODE_CORDIC   = 2'd0;
  localparam logic [1:0] MODE_DEN_ZERO = 2'd1;
  localparam logic [1:0] MODE_NUM_ZERO = 2'd2;

  // quadrant offset codes
  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_BOX_WIDTH  = 1'b0;
  localparam logic REG_BOX_HEIGHT = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [1:0] quad;
    logic [1:0] mode;
  } ctl_t;

  // atan(2^-i) in degrees, 2^16 scale
  function automatic logic [ATAN_W-1:0] atan_tab(input int unsigned idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      0:  r = ATAN_W'(2949120);
      1:  r = ATAN_W'(1740967);
      2:  r = ATAN_W'(919879);
      3:  r = ATAN_W'(466945);
      4:  r = ATAN_W'(234379);
      5:  r = ATAN_W'(117304);
      6:  r = ATAN_W'(58666);
      7:  r = ATAN_W'(29335);
      8:  r = ATAN_W'(14668);
      9:  r = ATAN_W'(7334);
      10: r = ATAN_W'(3667);
      11: r = ATAN_W'(1833);
      12: r = ATAN_W'(917);
      13: r = ATAN_W'(458);
      14: r = ATAN_W'(229);
      15: r = ATAN_W'(115);
      16: r = ATAN_W'(57);
      17: r = ATAN_W'(29);
      18: r = ATAN_W'(14);
      19: r = ATAN_W'(7);
      20: r = ATAN_W'(4);
      21: r = ATAN_W'(2);
      22: r = ATAN_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [HEADING_W-1:0] quad_offset(input logic [1:0] quad);
    logic [HEADING_W-1:0] r;
    case (quad)
      QUAD_0:   r = '0;
      QUAD_90:  r = HEADING_W'(90 << ANGLE_FRAC_BITS);
      QUAD_180: r = HEADING_W'(180 << ANGLE_FRAC_BITS);
      QUAD_270: r = HEADING_W'(270 << ANGLE_FRAC_BITS);
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/tha_prep.sv
// front end: box-centre vector, quadrant choice and special cases, two stages
// depends on tha_pkg
module tha_prep (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [tha_pkg::TGT_W-1:0]    target_x,
  input  logic signed [tha_pkg::TGT_W-1:0]    target_y,
  input  logic signed [tha_pkg::CORNER_W-1:0] corner_x,
  input  logic signed [tha_pkg::CORNER_W-1:0] corner_y,
  input  logic [tha_pkg::BOX_W-1:0]        box_width,
  input  logic [tha_pkg::BOX_W-1:0]        box_height,
  output tha_pkg::ctl_t                    ctl,
  output logic [tha_pkg::MAG_W-1:0]        num,
  output logic [tha_pkg::MAG_W-1:0]        den
);
  import tha_pkg::*;

  logic signed [VEC_W-1:0] tx_ext, ty_ext, cx_ext, cy_ext, bw_ext, bh_ext;
  logic signed [VEC_W-1:0] vx, vy, vx_next, vy_next, vx_abs, vy_abs;
  logic                    valid_a;
  logic [MAG_W-1:0]        mx, my, num_next, den_next;
  tha_pkg::ctl_t           ctl_next;

  assign tx_ext = VEC_W'(target_x);
  assign ty_ext = VEC_W'(target_y);
  assign cx_ext = VEC_W'(corner_x);
  assign cy_ext = VEC_W'(corner_y);
  assign bw_ext = $signed({{(VEC_W-BOX_W){1'b0}}, box_width});
  assign bh_ext = $signed({{(VEC_W-BOX_W){1'b0}}, box_height});

  // vector in units of 2^-(POS_FRAC_BITS+1) pixel
  assign vx_next = (tx_ext <<< (POS_FRAC_BITS + 1)) - (cx_ext <<< 1) - bw_ext;
  assign vy_next = (ty_ext <<< (POS_FRAC_BITS + 1)) - (cy_ext <<< 1) - bh_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
    end
    if (en) begin
      vx <= vx_next;
      vy <= vy_next;
    end
  end

  assign vx_abs = vx[VEC_W-1] ? -vx : vx;
  assign vy_abs = vy[VEC_W-1] ? -vy : vy;
  assign mx     = vx_abs[MAG_W-1:0];
  assign my     = vy_abs[MAG_W-1:0];

  always_comb begin
    ctl_next.valid = valid_a;
    case ({vx[VEC_W-1], vy[VEC_W-1]})
      2'b00: begin
        num_next = my; den_next = mx; ctl_next.quad = QUAD_90;
      end
      2'b10: begin
        num_next = mx; den_next = my; ctl_next.quad = QUAD_180;
      end
      2'b11: begin
        num_next = my; den_next = mx; ctl_next.quad = QUAD_270;
      end
      default: begin
        num_next = mx; den_next = my; ctl_next.quad = QUAD_0;
      end
    endcase
    // zero vector lands in the first arm and reads as 90 degrees
    if (den_next == '0 && num_next != '0) begin
      ctl_next.mode = MODE_DEN_ZERO;
    end else if (num_next == '0) begin
      ctl_next.mode = MODE_NUM_ZERO;
    end else begin
      ctl_next.mode = MODE_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_next;
    end
    if (en) begin
      num <= num_next;
      den <= den_next;
    end
  end

endmodule

>>> hw/rtl/tha_norm.sv
// normalizer: shifts num and den left together until the larger has bit 30 set
// depends on tha_pkg; one registered stage per shift amount
module tha_norm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  tha_pkg::ctl_t              ctl_in,
  input  logic [tha_pkg::MAG_W-1:0]  num_in,
  input  logic [tha_pkg::MAG_W-1:0]  den_in,
  output tha_pkg::ctl_t              ctl_out,
  output logic [tha_pkg::NORM_W-1:0] num_out,
  output logic [tha_pkg::NORM_W-1:0] den_out
);
  import tha_pkg::*;

  tha_pkg::ctl_t     st_ctl [NORM_STAGES+1];
  logic [NORM_W-1:0] st_num [NORM_STAGES+1];
  logic [NORM_W-1:0] st_den [NORM_STAGES+1];

  assign st_ctl[0] = ctl_in;
  assign st_num[0] = {{(NORM_W-MAG_W){1'b0}}, num_in};
  assign st_den[0] = {{(NORM_W-MAG_W){1'b0}}, den_in};

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_stage
    localparam int SH = 1 << (NORM_STAGES - 1 - k);
    logic [NORM_W-1:0] both;
    logic              top_zero;

    assign both     = st_num[k] | st_den[k];
    assign top_zero = ~|both[NORM_W-1 -: SH];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[k+1] <= '0;
      end else if (en) begin
        st_ctl[k+1] <= st_ctl[k];
      end
      if (en) begin
        st_num[k+1] <= top_zero ? (st_num[k] << SH) : st_num[k];
        st_den[k+1] <= top_zero ? (st_den[k] << SH) : st_den[k];
      end
    end
  end

  assign ctl_out = st_ctl[NORM_STAGES];
  assign num_out = st_num[NORM_STAGES];
  assign den_out = st_den[NORM_STAGES];

endmodule

>>> hw/rtl/tha_cell.sv
// one vectoring cordic step, registered; a row of these forms the rotator
// depends on tha_pkg (arctangent table)
module tha_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  tha_pkg::ctl_t                   ctl_in,
  input  logic signed [tha_pkg::XY_W-1:0] x_in,
  input  logic signed [tha_pkg::XY_W-1:0] y_in,
  input  logic signed [tha_pkg::Z_W-1:0]  z_in,
  output tha_pkg::ctl_t                   ctl_out,
  output logic signed [tha_pkg::XY_W-1:0] x_out,
  output logic signed [tha_pkg::XY_W-1:0] y_out,
  output logic signed [tha_pkg::Z_W-1:0]  z_out
);
  import tha_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = $signed({{(Z_W-ATAN_W){1'b0}}, atan_tab(IDX)});

  logic signed [XY_W-1:0] xs, ys;
  logic                   y_pos;

  // arithmetic shift rounds toward minus infinity
  assign xs    = x_in >>> IDX;
  assign ys    = y_in >>> IDX;
  assign y_pos = ~y_in[XY_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      x_out <= y_pos ? x_in + ys : x_in - ys;
      y_out <= y_pos ? y_in - xs : y_in + xs;
      z_out <= y_pos ? z_in + ANGLE : z_in - ANGLE;
    end
  end

endmodule

>>> hw/rtl/tha_post.sv
// back end: clamp and round the angle, add the quadrant offset, output skid
// depends on tha_pkg; drives the pipeline advance for the whole block
module tha_post (
  input  logic                                clk,
  input  logic                                rst,
  output logic                                en,
  input  tha_pkg::ctl_t                       ctl_in,
  input  logic signed [tha_pkg::Z_W-1:0]      z_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tha_pkg::HEADING_W-1:0]       heading,
  output logic [tha_pkg::SPRITE_W-1:0]        sprite_angle
);
  import tha_pkg::*;

  logic [CLAMP_W-1:0]   zc;
  logic [CLAMP_W:0]     rsum;
  logic [PART_W-1:0]    part_next, part;
  logic                 p_valid;
  logic [1:0]           p_quad;
  logic [HEADING_W-1:0] head_next, skid_head;
  logic [SPRITE_W-1:0]  sprite_next, skid_sprite;
  logic                 skid_valid;
  logic                 push;

  assign en = ~skid_valid;

  always_comb begin
    if (z_in[Z_W-1]) begin
      zc = '0;
    end else if (z_in > $signed({{(Z_W-CLAMP_W){1'b0}}, Z_MAX})) begin
      zc = Z_MAX;
    end else begin
      zc = z_in[CLAMP_W-1:0];
    end
    rsum = {1'b0, zc} + (CLAMP_W+1)'(1 << (ROUND_SHIFT - 1));
    case (ctl_in.mode)
      MODE_DEN_ZERO: part_next = PART_RIGHT;
      MODE_NUM_ZERO: part_next = '0;
      default:       part_next = rsum[ROUND_SHIFT +: PART_W];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= ctl_in.valid;
    end
    if (en) begin
      part   <= part_next;
      p_quad <= ctl_in.quad;
    end
  end

  assign head_next   = quad_offset(p_quad) + HEADING_W'(part);
  assign sprite_next = SPRITE_W'(head_next) + SPRITE_OFFSET;
  assign push        = en & p_valid;

  // output register plus one skid entry; the pipeline holds while the skid is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        heading      <= skid_head;
        sprite_angle <= skid_sprite;
      end else if (push) begin
        heading      <= head_next;
        sprite_angle <= sprite_next;
      end
    end else if (push) begin
      skid_head   <= head_next;
      skid_sprite <= sprite_next;
    end
  end

endmodule

>>> hw/rtl/target_heading_angle_unit.sv
// top level of the target heading unit: register port, front end, normalizer,
// cordic cell row and back end; depends on tha_pkg, tha_prep, tha_norm,
// tha_cell and tha_post
//
// usage
//   in_valid/in_ready carries one request: target point in whole pixels and
//   the entity box corner with four fraction bits; out_valid/out_ready returns
//   heading and sprite angle (heading plus 180 degrees) in 1/256 degree
//   box_width (offset 0) and box_height (offset 4) are set over the
//   register port while no request is in flight; both reset to zero
// timing
//   one request per cycle while in_ready is high; the row of CORDIC_STEPS cells
//   (capped at 24) holds one request per cell, every stage advancing together
//   from acceptance to out_valid a request passes two front end stages, five
//   normalizer stages, the cells, a rounding stage and the output register
// reset: synchronous rst clears every stage valid, the output and skid valid
//   flags, and both box registers
// back pressure: while out_ready is low the output register holds; one more
//   result goes to a skid entry, and only while that entry is full does
//   in_ready drop and the whole pipeline freeze
module target_heading_angle_unit #(
  parameter int CORDIC_STEPS = tha_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tha_pkg::ADDR_W-1:0]           paddr,
  input  logic [tha_pkg::DATA_W-1:0]           pwdata,
  output logic [tha_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tha_pkg::TGT_W-1:0]     target_x,
  input  logic signed [tha_pkg::TGT_W-1:0]     target_y,
  input  logic signed [tha_pkg::CORNER_W-1:0]  corner_x,
  input  logic signed [tha_pkg::CORNER_W-1:0]  corner_y,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tha_pkg::HEADING_W-1:0]        heading,
  output logic [tha_pkg::SPRITE_W-1:0]         sprite_angle
);
  import tha_pkg::*;

  localparam int NUM_CELLS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic [BOX_W-1:0]  box_width, box_height;
  logic              en;
  logic              wr;

  tha_pkg::ctl_t     prep_ctl, norm_ctl;
  logic [MAG_W-1:0]  prep_num, prep_den;
  logic [NORM_W-1:0] norm_num, norm_den;

  // per-cell taps of the rotator row
  tha_pkg::ctl_t          c_ctl [NUM_CELLS+1];
  logic signed [XY_W-1:0] c_x   [NUM_CELLS+1];
  logic signed [XY_W-1:0] c_y   [NUM_CELLS+1];
  logic signed [Z_W-1:0]  c_z   [NUM_CELLS+1];

  // register port: no wait states, word decode on paddr[2]
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= '0;
      box_height <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        REG_BOX_WIDTH:  box_width  <= pwdata[BOX_W-1:0];
        REG_BOX_HEIGHT: box_height <= pwdata[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BOX_WIDTH:  prdata = DATA_W'(box_width);
      REG_BOX_HEIGHT: prdata = DATA_W'(box_height);
      default:        prdata = '0;
    endcase
  end

  // whole pipeline advances together unless the output skid is full
  assign in_ready = en;

  tha_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .target_x   (target_x),
    .target_y   (target_y),
    .corner_x   (corner_x),
    .corner_y   (corner_y),
    .box_width  (box_width),
    .box_height (box_height),
    .ctl        (prep_ctl),
    .num        (prep_num),
    .den        (prep_den)
  );

  tha_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (prep_ctl),
    .num_in  (prep_num),
    .den_in  (prep_den),
    .ctl_out (norm_ctl),
    .num_out (norm_num),
    .den_out (norm_den)
  );

  // rotator starts from (den, num) with zero angle
  assign c_ctl[0] = norm_ctl;
  assign c_x[0]   = $signed({{(XY_W-NORM_W){1'b0}}, norm_den});
  assign c_y[0]   = $signed({{(XY_W-NORM_W){1'b0}}, norm_num});
  assign c_z[0]   = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tha_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (c_ctl[i]),
      .x_in    (c_x[i]),
      .y_in    (c_y[i]),
      .z_in    (c_z[i]),
      .ctl_out (c_ctl[i+1]),
      .x_out   (c_x[i+1]),
      .y_out   (c_y[i+1]),
      .z_out   (c_z[i+1])
    );
  end

  // only the angle leaves the row; x and y of the last cell are not needed
  tha_post u_post (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .ctl_in       (c_ctl[NUM_CELLS]),
    .z_in         (c_z[NUM_CELLS]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .heading      (heading),
    .sprite_angle (sprite_angle)
  );

endmodule
